// ===== hw/rtl/tmse_pkg.sv =====
// tmse_pkg: sizes, codes and shared types of the turing machine step engine
// no dependencies; imported by tmse_ctrl, tmse_dp and turing_machine_step_engine
package tmse_pkg;

	localparam int RULE_SLOTS  = 64;
	localparam int TAPE_CELLS  = 1024;
	localparam int STATE_COUNT = 64;

	localparam int SLOT_W  = $clog2(RULE_SLOTS);
	localparam int TAPE_AW = $clog2(TAPE_CELLS);

	localparam logic [2:0] MODE_LOAD  = 3'd0;
	localparam logic [2:0] MODE_WRITE = 3'd1;
	localparam logic [2:0] MODE_START = 3'd2;
	localparam logic [2:0] MODE_STEP  = 3'd3;
	localparam logic [2:0] MODE_READ  = 3'd4;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_HALTED    = 3'd1;
	localparam logic [2:0] ST_NO_CELL   = 3'd2;
	localparam logic [2:0] ST_OFF_TAPE  = 3'd3;
	localparam logic [2:0] ST_NO_STATE  = 3'd4;
	localparam logic [2:0] ST_UNKNOWN   = 3'd5;
	localparam logic [2:0] ST_LOADED    = 3'd6;

	localparam logic [1:0] MOVE_RIGHT = 2'd1;
	localparam logic [1:0] MOVE_LEFT  = 2'd2;

	typedef struct packed {
		logic [5:0] state;
		logic [7:0] symbol;
		logic [5:0] goto_state;
		logic [7:0] write_symbol;
		logic [1:0] move;
		logic       halt;
	} rule_t;

	typedef struct packed {
		logic       capture;
		logic       tape_clr;
		logic       load_rule;
		logic       tape_wr;
		logic       start;
		logic       rd_idx;
		logic       rd_head;
		logic       cell_load;
		logic       scan_init;
		logic       scan_run;
		logic       apply;
		logic       res_load;
		logic [2:0] res_status;
	} cmd_t;

	typedef struct packed {
		logic [2:0] mode;
		logic       clr_last;
		logic       no_cell;
		logic       off_tape;
		logic       no_state;
		logic       hit;
		logic       hit_halt;
		logic       known;
		logic       scan_last;
	} sts_t;

endpackage

// ===== hw/rtl/turing_machine_step_engine.sv =====
// turing_machine_step_engine: single-tape turing machine driven by one request at a time
// Channels: in_valid/in_stall carries a request (mode plus rule, cell and start fields);
// out_valid/out_stall returns exactly one result per request, in request order.
// A request is taken when valid is high and stall is low; in_stall is high while
// a request is being worked on, so requests are handled strictly one after another.
// A step whose checks pass scans the rule slots from the highest down, at most 64 of them,
// one slot per cycle through the rule memory; a step that fires then rereads the cell
// under the new head position.
// The result sits in an output register: the next request is accepted while it waits,
// and that request holds in its last cycle until out_stall drops.
// After reset the tape memory is cleared to blank, one cell per cycle, with in_stall high
// until every cell is blank. Reset also empties all rule slots, puts the head at -1, leaves
// the machine without a state and zeroes the step count.
// depends on tmse_pkg, tmse_ctrl, tmse_dp
module turing_machine_step_engine
	import tmse_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         mode,
	input  logic [5:0]         rule_index,
	input  logic               rule_valid,
	input  logic [5:0]         rule_state,
	input  logic [7:0]         rule_symbol,
	input  logic [5:0]         rule_next_state,
	input  logic [7:0]         rule_next_symbol,
	input  logic [1:0]         rule_move,
	input  logic               rule_final,
	input  logic signed [10:0] cell_index,
	input  logic [7:0]         cell_symbol,
	input  logic [6:0]         start_state,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic [6:0]         state_now,
	output logic signed [11:0] head_now,
	output logic [31:0]        steps_done,
	output logic [7:0]         cell_value,
	output logic [5:0]         fired_rule
);

	cmd_t cmd;
	sts_t sts;

	tmse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	tmse_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.mode             (mode),
		.rule_index       (rule_index),
		.rule_valid       (rule_valid),
		.rule_state       (rule_state),
		.rule_symbol      (rule_symbol),
		.rule_next_state  (rule_next_state),
		.rule_next_symbol (rule_next_symbol),
		.rule_move        (rule_move),
		.rule_final       (rule_final),
		.cell_index       (cell_index),
		.cell_symbol      (cell_symbol),
		.start_state      (start_state),
		.status           (status),
		.state_now        (state_now),
		.head_now         (head_now),
		.steps_done       (steps_done),
		.cell_value       (cell_value),
		.fired_rule       (fired_rule)
	);

endmodule

// ===== hw/rtl/tmse_ctrl.sv =====
// tmse_ctrl: sequencer of the step engine, drives the handshakes and the datapath commands
// depends on tmse_pkg
module tmse_ctrl
	import tmse_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	output cmd_t cmd,
	input  sts_t sts
);

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_EXEC   = 3'd2;
	localparam logic [2:0] S_RDWAIT = 3'd3;
	localparam logic [2:0] S_CHECK  = 3'd4;
	localparam logic [2:0] S_SCAN   = 3'd5;
	localparam logic [2:0] S_REREAD = 3'd6;
	localparam logic [2:0] S_FINISH = 3'd7;

	logic [2:0] state_q, state_d;
	logic [2:0] res_q, res_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		res_d   = res_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.tape_clr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				res_d   = ST_OK;
				state_d = S_FINISH;
				case (sts.mode)
					MODE_LOAD: begin
						cmd.load_rule = 1'b1;
						res_d         = ST_LOADED;
					end
					MODE_WRITE: begin
						cmd.tape_wr = 1'b1;
					end
					MODE_START: begin
						cmd.start = 1'b1;
					end
					MODE_READ: begin
						cmd.rd_idx = 1'b1;
						state_d    = S_RDWAIT;
					end
					MODE_STEP: begin
						cmd.rd_head = 1'b1;
						state_d     = S_CHECK;
					end
					default: begin
						state_d = S_FINISH;
					end
				endcase
			end
			S_RDWAIT: begin
				cmd.cell_load = 1'b1;
				state_d       = S_FINISH;
			end
			S_CHECK: begin
				cmd.cell_load = 1'b1;
				state_d       = S_FINISH;
				if (sts.no_cell) begin
					res_d = ST_NO_CELL;
				end else if (sts.off_tape) begin
					res_d = ST_OFF_TAPE;
				end else if (sts.no_state) begin
					res_d = ST_NO_STATE;
				end else begin
					cmd.scan_init = 1'b1;
					state_d       = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.hit) begin
					cmd.apply = 1'b1;
					res_d     = sts.hit_halt ? ST_HALTED : ST_OK;
					state_d   = S_REREAD;
				end else if (sts.scan_last) begin
					res_d   = sts.known ? ST_HALTED : ST_UNKNOWN;
					state_d = S_FINISH;
				end else begin
					cmd.scan_run = 1'b1;
				end
			end
			S_REREAD: begin
				cmd.rd_head = 1'b1;
				state_d     = S_RDWAIT;
			end
			S_FINISH: begin
				cmd.res_status = res_q;
				if (out_free) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			res_q       <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/tmse_dp.sv =====
// tmse_dp: request registers, rule and tape memories, machine registers, result register
// depends on tmse_pkg; commanded by tmse_ctrl
module tmse_dp
	import tmse_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic [2:0]         mode,
	input  logic [5:0]         rule_index,
	input  logic               rule_valid,
	input  logic [5:0]         rule_state,
	input  logic [7:0]         rule_symbol,
	input  logic [5:0]         rule_next_state,
	input  logic [7:0]         rule_next_symbol,
	input  logic [1:0]         rule_move,
	input  logic               rule_final,
	input  logic signed [10:0] cell_index,
	input  logic [7:0]         cell_symbol,
	input  logic [6:0]         start_state,
	output logic [2:0]         status,
	output logic [6:0]         state_now,
	output logic signed [11:0] head_now,
	output logic [31:0]        steps_done,
	output logic [7:0]         cell_value,
	output logic [5:0]         fired_rule
);

	localparam logic signed [11:0] TAPE_END = 12'(TAPE_CELLS);

	// request registers
	logic [2:0]         mode_q;
	logic [5:0]         rule_index_q;
	logic               rule_valid_q;
	rule_t              rule_in_q;
	logic signed [10:0] cell_index_q;
	logic [7:0]         cell_symbol_q;
	logic [6:0]         start_state_q;

	// machine registers
	logic signed [11:0] head_q;
	logic [6:0]         mstate_q;
	logic [31:0]        steps_q;
	logic [7:0]         cell_q;
	logic [5:0]         fired_q;

	// memories
	rule_t              rule_mem [RULE_SLOTS];
	logic [7:0]         tape_mem [TAPE_CELLS];
	logic               vld_q [RULE_SLOTS];

	logic [TAPE_AW-1:0] clr_cnt_q;
	logic [SLOT_W-1:0]  scan_addr_q;
	logic [SLOT_W-1:0]  slot_s1;
	logic               ev_valid_s1;
	rule_t              rule_rd_s1;
	logic               known_q;
	logic [7:0]         tape_rd_s1;
	logic               rd_ok_s1;

	logic               idx_on_tape;
	logic               head_on_tape;
	logic               tape_we;
	logic [TAPE_AW-1:0] tape_wa;
	logic [7:0]         tape_wd;
	logic               tape_re;
	logic [TAPE_AW-1:0] tape_ra;
	logic               state_hit;
	logic               sym_hit;
	logic               known_now;
	logic signed [10:0] head_ext_idx;

	assign idx_on_tape  = !cell_index_q[10] && (int'(cell_index_q) < TAPE_CELLS);
	assign head_on_tape = !head_q[11] && (head_q < TAPE_END);
	assign head_ext_idx = cell_index_q;

	assign state_hit = ev_valid_s1 && vld_q[slot_s1] && (rule_rd_s1.state == mstate_q[5:0]);
	assign sym_hit   = (rule_rd_s1.symbol == 8'd0) || (rule_rd_s1.symbol == cell_q);
	assign known_now = state_hit;

	always_comb begin
		sts           = '0;
		sts.mode      = mode_q;
		sts.clr_last  = (clr_cnt_q == TAPE_AW'(TAPE_CELLS - 1));
		sts.no_cell   = (steps_q == 32'd0) && head_q[11];
		sts.off_tape  = !head_on_tape;
		sts.no_state  = (int'(mstate_q) >= STATE_COUNT);
		sts.hit       = state_hit && sym_hit;
		sts.hit_halt  = rule_rd_s1.halt;
		sts.known     = known_q || known_now;
		sts.scan_last = ev_valid_s1 && (slot_s1 == '0);
	end

	// tape port selection
	always_comb begin
		tape_we = 1'b0;
		tape_wa = clr_cnt_q;
		tape_wd = 8'd0;
		if (cmd.tape_clr) begin
			tape_we = 1'b1;
		end else if (cmd.tape_wr) begin
			tape_we = idx_on_tape;
			tape_wa = cell_index_q[TAPE_AW-1:0];
			tape_wd = cell_symbol_q;
		end else if (cmd.apply) begin
			tape_we = (rule_rd_s1.write_symbol != 8'd0);
			tape_wa = head_q[TAPE_AW-1:0];
			tape_wd = rule_rd_s1.write_symbol;
		end
		tape_re = cmd.rd_idx || cmd.rd_head;
		tape_ra = cmd.rd_idx ? cell_index_q[TAPE_AW-1:0] : head_q[TAPE_AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (tape_we) begin
			tape_mem[tape_wa] <= tape_wd;
		end
		if (tape_re) begin
			tape_rd_s1 <= tape_mem[tape_ra];
			rd_ok_s1   <= cmd.rd_idx ? idx_on_tape : head_on_tape;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_rule && (int'(rule_index_q) < RULE_SLOTS)) begin
			rule_mem[rule_index_q[SLOT_W-1:0]] <= rule_in_q;
		end
		if (cmd.scan_run) begin
			rule_rd_s1 <= rule_mem[scan_addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RULE_SLOTS; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (cmd.load_rule && (int'(rule_index_q) < RULE_SLOTS)) begin
			vld_q[rule_index_q[SLOT_W-1:0]] <= rule_valid_q;
		end
	end

	// requests and result payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q                 <= mode;
			rule_index_q           <= rule_index;
			rule_valid_q           <= rule_valid;
			rule_in_q.state        <= rule_state;
			rule_in_q.symbol       <= rule_symbol;
			rule_in_q.goto_state   <= rule_next_state;
			rule_in_q.write_symbol <= rule_next_symbol;
			rule_in_q.move         <= rule_move;
			rule_in_q.halt         <= rule_final;
			cell_index_q           <= cell_index;
			cell_symbol_q          <= cell_symbol;
			start_state_q          <= start_state;
			cell_q                 <= 8'd0;
			fired_q                <= 6'd0;
		end
		if (cmd.cell_load) begin
			cell_q <= rd_ok_s1 ? tape_rd_s1 : 8'd0;
		end
		if (cmd.apply) begin
			fired_q <= 6'(slot_s1);
		end
		if (cmd.scan_run) begin
			slot_s1 <= scan_addr_q;
		end
		if (cmd.res_load) begin
			status     <= cmd.res_status;
			state_now  <= mstate_q;
			head_now   <= head_q;
			steps_done <= steps_q;
			cell_value <= cell_q;
			fired_rule <= fired_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= -12'sd1;
			mstate_q    <= 7'(STATE_COUNT);
			steps_q     <= 32'd0;
			clr_cnt_q   <= '0;
			scan_addr_q <= '0;
			ev_valid_s1 <= 1'b0;
			known_q     <= 1'b0;
		end else begin
			if (cmd.tape_clr) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (cmd.start) begin
				head_q   <= {head_ext_idx[10], head_ext_idx};
				mstate_q <= (int'(start_state_q) < STATE_COUNT) ? start_state_q
				                                               : 7'(STATE_COUNT);
				steps_q  <= 32'd0;
			end
			if (cmd.scan_init) begin
				scan_addr_q <= SLOT_W'(RULE_SLOTS - 1);
				ev_valid_s1 <= 1'b0;
				known_q     <= 1'b0;
			end else if (cmd.scan_run) begin
				scan_addr_q <= scan_addr_q - 1'b1;
				ev_valid_s1 <= 1'b1;
				if (known_now) begin
					known_q <= 1'b1;
				end
			end
			if (cmd.apply) begin
				if (rule_rd_s1.move == MOVE_RIGHT) begin
					head_q <= head_q + 12'sd1;
				end else if (rule_rd_s1.move == MOVE_LEFT) begin
					head_q <= head_q - 12'sd1;
				end
				mstate_q <= {1'b0, rule_rd_s1.goto_state};
				if (steps_q != 32'hFFFF_FFFF) begin
					steps_q <= steps_q + 32'd1;
				end
			end
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking testbench of the turing machine step engine
// keeps its own copy of rules, tape, head, state and step count and checks every result
// depends on tmse_pkg and turing_machine_step_engine
`timescale 1ns / 100ps

module tb_top
	import tmse_pkg::*;
();

	localparam int          IDLE_LIMIT     = 4000;
	localparam int          DRAIN_CYCLES   = 80;
	localparam int          HOLD_CYCLES    = 300;
	localparam logic [2:0]  MODE_UNUSED_LO = 3'd5;
	localparam logic [2:0]  MODE_UNUSED_HI = 3'd7;
	localparam logic [1:0]  MOVE_NONE      = 2'd0;
	localparam logic [1:0]  MOVE_HOLD      = 2'd3;

	typedef struct packed {
		logic [2:0]         mode;
		logic [5:0]         rule_index;
		logic               rule_valid;
		logic [5:0]         rule_state;
		logic [7:0]         rule_symbol;
		logic [5:0]         rule_next_state;
		logic [7:0]         rule_next_symbol;
		logic [1:0]         rule_move;
		logic               rule_final;
		logic signed [10:0] cell_index;
		logic [7:0]         cell_symbol;
		logic [6:0]         start_state;
	} tm_req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [6:0]         state_now;
		logic signed [11:0] head;
		logic [31:0]        steps;
		logic [7:0]         cell_sym;
		logic [5:0]         fired;
	} step_result_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [2:0]         mode;
	logic [5:0]         rule_index;
	logic               rule_valid;
	logic [5:0]         rule_state;
	logic [7:0]         rule_symbol;
	logic [5:0]         rule_next_state;
	logic [7:0]         rule_next_symbol;
	logic [1:0]         rule_move;
	logic               rule_final;
	logic signed [10:0] cell_index;
	logic [7:0]         cell_symbol;
	logic [6:0]         start_state;
	logic               out_valid;
	logic               out_stall;
	logic [2:0]         status;
	logic [6:0]         state_now;
	logic signed [11:0] head_now;
	logic [31:0]        steps_done;
	logic [7:0]         cell_value;
	logic [5:0]         fired_rule;

	rule_t        rule_copy [RULE_SLOTS];
	bit           rule_live [RULE_SLOTS];
	logic [7:0]   tape_copy [TAPE_CELLS];
	int           head_pos;
	int           cur_state;
	logic [31:0]  step_cnt;

	step_result_t pending_results [$];
	int           mismatches;
	int           sent_count;
	int           idle_cycles;
	int           rx_hold;
	bit           no_gaps;

	turing_machine_step_engine u_top (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic bit on_tape(input int p);
		return p >= 0 && p < TAPE_CELLS;
	endfunction

	function automatic step_result_t advance_machine(input tm_req_t r);
		step_result_t res;
		int           idx;
		int           sym;
		bit           known;
		bit           done;
		res = '0;
		idx = $signed(r.cell_index);
		case (r.mode)
			MODE_LOAD: begin
				rule_live[r.rule_index] = r.rule_valid;
				rule_copy[r.rule_index] = '{state: r.rule_state, symbol: r.rule_symbol,
					goto_state: r.rule_next_state, write_symbol: r.rule_next_symbol,
					move: r.rule_move, halt: r.rule_final};
				res.status = ST_LOADED;
			end
			MODE_WRITE: begin
				if (on_tape(idx))
					tape_copy[idx] = r.cell_symbol;
			end
			MODE_START: begin
				head_pos = idx;
				cur_state = (r.start_state < STATE_COUNT) ? int'(r.start_state) : STATE_COUNT;
				step_cnt = '0;
			end
			MODE_STEP: begin
				res.cell_sym = on_tape(head_pos) ? tape_copy[head_pos] : 8'd0;
				known = 1'b0;
				for (int i = 0; i < RULE_SLOTS; i++)
					if (rule_live[i] && int'(rule_copy[i].state) == cur_state)
						known = 1'b1;
				if (step_cnt == 0 && head_pos < 0)
					res.status = ST_NO_CELL;
				else if (!on_tape(head_pos))
					res.status = ST_OFF_TAPE;
				else if (cur_state >= STATE_COUNT)
					res.status = ST_NO_STATE;
				else if (!known)
					res.status = ST_UNKNOWN;
				else begin
					res.status = ST_HALTED;
					sym = tape_copy[head_pos];
					done = 1'b0;
					for (int i = RULE_SLOTS - 1; i >= 0 && !done; i--) begin
						if (rule_live[i] && int'(rule_copy[i].state) == cur_state &&
							(rule_copy[i].symbol == 0 || int'(rule_copy[i].symbol) == sym)) begin
							done = 1'b1;
							if (rule_copy[i].write_symbol != 0)
								tape_copy[head_pos] = rule_copy[i].write_symbol;
							if (rule_copy[i].move == MOVE_RIGHT)
								head_pos++;
							else if (rule_copy[i].move == MOVE_LEFT)
								head_pos--;
							cur_state = rule_copy[i].goto_state;
							if (step_cnt != '1)
								step_cnt++;
							res.fired = i[5:0];
							res.cell_sym = on_tape(head_pos) ? tape_copy[head_pos] : 8'd0;
							res.status = rule_copy[i].halt ? ST_HALTED : ST_OK;
						end
					end
				end
			end
			MODE_READ: begin
				if (on_tape(idx))
					res.cell_sym = tape_copy[idx];
			end
			default: ;
		endcase
		res.state_now = cur_state[6:0];
		res.head = head_pos[11:0];
		res.steps = step_cnt;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("%0t mismatch in %s: got %0h expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		step_result_t got;
		step_result_t want;
		if (out_valid === 1'b1 && out_stall === 1'b0) begin
			got = '{status, state_now, head_now, steps_done, cell_value, fired_rule};
			if (pending_results.size() == 0)
				report_mismatch("result with no request waiting", 32'(got.status), '0);
			else begin
				want = pending_results.pop_front();
				if (got.status !== want.status)
					report_mismatch("status", 32'(got.status), 32'(want.status));
				if (got.state_now !== want.state_now)
					report_mismatch("state_now", 32'(got.state_now), 32'(want.state_now));
				if (got.head !== want.head)
					report_mismatch("head_now", 32'(got.head), 32'(want.head));
				if (got.steps !== want.steps)
					report_mismatch("steps_done", got.steps, want.steps);
				if (got.cell_sym !== want.cell_sym)
					report_mismatch("cell_value", 32'(got.cell_sym), 32'(want.cell_sym));
				if (got.fired !== want.fired)
					report_mismatch("fired_rule", 32'(got.fired), 32'(want.fired));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid === 1'b1 && in_stall === 1'b0) ||
			(out_valid === 1'b1 && out_stall === 1'b0))
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("turing_machine_step_engine test failed");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// result side: random stall before each result, long hold when asked
	initial begin
		int n;
		forever begin
			if (rx_hold > 0) begin
				n = rx_hold;
				rx_hold = 0;
			end else
				n = no_gaps ? 0 : $urandom_range(0, 7);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
		end
	end

	task automatic send_req(input tm_req_t r);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 7);
		repeat (gap) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		mode             <= r.mode;
		rule_index       <= r.rule_index;
		rule_valid       <= r.rule_valid;
		rule_state       <= r.rule_state;
		rule_symbol      <= r.rule_symbol;
		rule_next_state  <= r.rule_next_state;
		rule_next_symbol <= r.rule_next_symbol;
		rule_move        <= r.rule_move;
		rule_final       <= r.rule_final;
		cell_index       <= r.cell_index;
		cell_symbol      <= r.cell_symbol;
		start_state      <= r.start_state;
		in_valid         <= 1'b1;
		do @(posedge clk); while (in_stall !== 1'b0);
		pending_results.insert(pending_results.size(), advance_machine(r));
		sent_count++;
	endtask

	function automatic tm_req_t rand_req();
		logic [95:0] bits;
		bits = {$urandom, $urandom, $urandom};
		return bits[$bits(tm_req_t)-1:0];
	endfunction

	function automatic tm_req_t mk_load(input int slot, input bit ok, input int st,
		input int sym, input int nst, input int nsym, input logic [1:0] mv, input bit fin);
		tm_req_t r;
		r = rand_req();
		r.mode = MODE_LOAD;
		r.rule_index = 6'(slot);
		r.rule_valid = ok;
		r.rule_state = 6'(st);
		r.rule_symbol = 8'(sym);
		r.rule_next_state = 6'(nst);
		r.rule_next_symbol = 8'(nsym);
		r.rule_move = mv;
		r.rule_final = fin;
		return r;
	endfunction

	function automatic tm_req_t mk_cell(input logic [2:0] md, input int idx, input int sym);
		tm_req_t r;
		r = rand_req();
		r.mode = md;
		r.cell_index = 11'(idx);
		r.cell_symbol = 8'(sym);
		return r;
	endfunction

	function automatic tm_req_t mk_start(input int idx, input int st);
		tm_req_t r;
		r = rand_req();
		r.mode = MODE_START;
		r.cell_index = 11'(idx);
		r.start_state = 7'(st);
		return r;
	endfunction

	function automatic tm_req_t mk_step();
		tm_req_t r;
		r = rand_req();
		r.mode = MODE_STEP;
		return r;
	endfunction

	// mostly a few symbols so that rules match often
	function automatic int pick_symbol();
		case ($urandom_range(0, 3))
			0: return 0;
			3: return $urandom_range(0, 255);
			default: return $urandom_range(1, 3);
		endcase
	endfunction

	task automatic test_idle_machine();
		send_req(mk_step());
		send_req(mk_cell(MODE_READ, 0, 0));
		send_req(mk_cell(MODE_READ, TAPE_CELLS - 1, 0));
		for (int md = MODE_UNUSED_LO; md <= MODE_UNUSED_HI; md++)
			send_req(mk_cell(md[2:0], $urandom_range(0, 2047), $urandom_range(0, 255)));
	endtask

	task automatic test_start_checks();
		send_req(mk_start(0, STATE_COUNT));
		send_req(mk_step());
		send_req(mk_start(3, 7'h7f));
		send_req(mk_step());
		send_req(mk_start(5, 9));
		send_req(mk_step());
	endtask

	task automatic test_rule_paths();
		send_req(mk_cell(MODE_WRITE, TAPE_CELLS - 1, 8'hff));
		send_req(mk_cell(MODE_WRITE, -1024, 8'h12));
		send_req(mk_cell(MODE_READ, -1024, 0));
		send_req(mk_load(RULE_SLOTS - 1, 1, 1, 0, 2, 8'hff, MOVE_RIGHT, 0));
		send_req(mk_load(0, 1, 2, 0, 2, 0, MOVE_LEFT, 1));
		// right off the end of the tape, then the off tape check
		send_req(mk_start(TAPE_CELLS - 1, 1));
		send_req(mk_step());
		send_req(mk_step());
		// final rule moves the head below zero
		send_req(mk_start(0, 2));
		send_req(mk_step());
		send_req(mk_step());
		// symbol match, no-move code, halt on no match, step after halt
		send_req(mk_load(10, 1, 3, 8'h55, 3, 1, MOVE_HOLD, 0));
		send_req(mk_start(7, 3));
		send_req(mk_step());
		send_req(mk_cell(MODE_WRITE, 7, 8'h55));
		send_req(mk_step());
		send_req(mk_step());
		// emptied slot leaves the state unknown
		send_req(mk_load(RULE_SLOTS - 1, 0, 1, 0, 0, 0, MOVE_NONE, 0));
		send_req(mk_start(TAPE_CELLS - 1, 1));
		send_req(mk_step());
	endtask

	task automatic test_backpressure();
		no_gaps = 1'b1;
		rx_hold = HOLD_CYCLES;
		repeat (12) send_req(($urandom_range(0, 1) == 0) ? mk_step() : rand_req());
		no_gaps = 1'b0;
	endtask

	task automatic test_random_programs(input int target);
		int ns;
		int base;
		int st;
		while (sent_count < target) begin
			ns = $urandom_range(1, 4);
			base = $urandom_range(0, TAPE_CELLS - 1);
			no_gaps = ($urandom_range(0, 5) == 0);
			repeat ($urandom_range(2, 8)) begin
				st = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, ns - 1);
				send_req(mk_load($urandom_range(0, 63), $urandom_range(0, 7) != 0, st,
					pick_symbol(), $urandom_range(0, ns - 1), pick_symbol(),
					2'($urandom_range(0, 3)), $urandom_range(0, 7) == 0));
			end
			repeat ($urandom_range(0, 6))
				send_req(mk_cell(MODE_WRITE, base + int'($urandom_range(0, 8)) - 4, pick_symbol()));
			send_req(mk_start(($urandom_range(0, 15) == 0) ? $urandom_range(0, 2047) : base,
				($urandom_range(0, 15) == 0) ? $urandom_range(0, 127) : $urandom_range(0, ns - 1)));
			repeat ($urandom_range(5, 40)) begin
				case ($urandom_range(0, 9))
					0: send_req(mk_cell(MODE_READ, base + int'($urandom_range(0, 8)) - 4, 0));
					1: send_req(mk_cell(MODE_WRITE, base + int'($urandom_range(0, 8)) - 4,
						pick_symbol()));
					default: send_req(mk_step());
				endcase
			end
		end
		no_gaps = 1'b0;
	endtask

	task automatic test_noise(input int count);
		repeat (count) send_req(rand_req());
	endtask

	initial begin
		foreach (rule_live[i]) rule_live[i] = 1'b0;
		foreach (rule_copy[i]) rule_copy[i] = '0;
		foreach (tape_copy[i]) tape_copy[i] = 8'd0;
		head_pos = -1;
		cur_state = STATE_COUNT;
		step_cnt = '0;
		mismatches = 0;
		sent_count = 0;
		idle_cycles = 0;
		rx_hold = 0;
		no_gaps = 1'b0;
		arst_n           <= 1'b0;
		in_valid         <= 1'b0;
		mode             <= '0;
		rule_index       <= '0;
		rule_valid       <= 1'b0;
		rule_state       <= '0;
		rule_symbol      <= '0;
		rule_next_state  <= '0;
		rule_next_symbol <= '0;
		rule_move        <= '0;
		rule_final       <= 1'b0;
		cell_index       <= '0;
		cell_symbol      <= '0;
		start_state      <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_idle_machine();
		test_start_checks();
		test_rule_paths();
		test_backpressure();
		test_random_programs(sent_count + 1100);
		test_noise(100);

		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("turing_machine_step_engine test passed");
		else
			$display("turing_machine_step_engine test failed");
		$finish;
	end

endmodule
